// ----- src/mpd_pkg.sv -----
// shared types and constants of the multi-pin debouncer
`default_nettype none

package mpd_pkg;

    localparam int VPIN_W    = 4;
    localparam int VPIN_CNT  = 16;
    localparam int DEB_W     = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PIN_MAP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEB_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEB_3   = 3'd4;

    localparam logic [CFG_W-1:0] PIN_MAP_RESET = 64'hFEDC_BA98_7654_3210;
    localparam logic [CFG_W-1:0] DEB_RESET     = 64'h0032_0032_0032_0032;

    typedef struct packed {
        logic acc;
        logic smp;
    } t_cell_bits;

    typedef struct packed {
        logic [VPIN_W-1:0] vpin;
        logic              level;
    } t_event;

endpackage

`default_nettype wire

// ----- src/mpd_cell.sv -----
// one physical pin cell of the rotating ring: accepted level and scan sample
`default_nettype none

module mpd_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load_smp,
    input  wire                  i_load_acc,
    input  wire                  i_bit,
    input  wire                  i_shift,
    input  wire mpd_pkg::t_cell_bits i_next,
    output mpd_pkg::t_cell_bits  o_bits
);

    logic r_acc;
    logic r_smp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 1'b0;
        end else if (i_load_acc) begin
            r_acc <= i_bit;
        end else if (i_shift) begin
            r_acc <= i_next.acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_smp) begin
            r_smp <= i_bit;
        end else if (i_shift) begin
            r_smp <= i_next.smp;
        end
    end

    assign o_bits.acc = r_acc;
    assign o_bits.smp = r_smp;

endmodule

`default_nettype wire

// ----- src/multi_pin_debounce_events.sv -----
// top level of the multi-pin debouncer: pin ring, per-virtual-pin timers, event output
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_kind, i_bank_a_byte, i_bank_b_byte, i_now_ms
//  out       output     o_out_valid / i_out_stall  o_virtual_pin, o_level, o_last
//  cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// a preload beat loads the accepted levels and leaves the block idle. a scan beat is accepted,
// then the ring of pin cells rotates past the head one pin per cycle, and the flush state
// releases the final event, if one is held.
// an event found while an earlier one is held and the output register is stalled
// holds the ring for every stalled cycle; the flush state waits the same way.
// reset clears accepted levels and pending flags and restores the map and debounce times.
// new beats are taken only while no scan is in progress.
`default_nettype none

module multi_pin_debounce_events #(
    parameter int PIN_COUNT = 16,
    parameter int TIME_BITS = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire                                 i_kind,
    input  wire  [7:0]                          i_bank_a_byte,
    input  wire  [7:0]                          i_bank_b_byte,
    input  wire  [31:0]                         i_now_ms,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [mpd_pkg::VPIN_W-1:0]          o_virtual_pin,
    output logic                                o_level,
    output logic                                o_last,
    input  wire                                 i_cfg_we,
    input  wire  [mpd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [mpd_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int STEP_W  = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam int VPIN_W  = mpd_pkg::VPIN_W;
    localparam int DEB_W   = mpd_pkg::DEB_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state                     r_state;
    logic [STEP_W-1:0]          r_step;
    logic [TIME_BITS-1:0]       r_now;
    mpd_pkg::t_event            r_held;
    logic                       r_held_valid;
    logic                       r_out_valid;
    mpd_pkg::t_event            r_out;
    logic                       r_out_last;

    logic [mpd_pkg::CFG_W-1:0]  r_pin_map;
    logic [mpd_pkg::CFG_W-1:0]  r_deb [4];

    logic [mpd_pkg::VPIN_CNT-1:0] r_pending;
    logic [TIME_BITS-1:0]         r_start [mpd_pkg::VPIN_CNT];

    mpd_pkg::t_cell_bits        w_cell [PIN_COUNT];
    mpd_pkg::t_cell_bits        w_tail;
    logic [15:0]                w_sample;
    logic                       w_in_accept;
    logic                       w_load_smp;
    logic                       w_load_acc;
    logic [VPIN_W-1:0]          w_vpin;
    logic [DEB_W-1:0]           w_deb;
    logic [TIME_BITS-1:0]       w_elapsed;
    logic                       w_diff;
    logic                       w_event;
    logic                       w_can_push;
    logic                       w_advance;
    logic                       w_shift;
    logic                       w_push;

    assign w_sample    = {i_bank_a_byte, i_bank_b_byte};
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_load_smp  = w_in_accept && !i_kind;
    assign w_load_acc  = w_in_accept && i_kind;

    // pin at the head of the ring is the one whose index equals the step count
    assign w_vpin    = r_pin_map[{VPIN_W'(r_step), 2'b00} +: VPIN_W];
    assign w_deb     = r_deb[w_vpin[3:2]][{w_vpin[1:0], 4'b0000} +: DEB_W];
    assign w_elapsed = r_now - r_start[w_vpin];
    assign w_diff    = (w_cell[0].smp != w_cell[0].acc);
    assign w_event   = w_diff && r_pending[w_vpin] && (w_elapsed > TIME_BITS'(w_deb));

    assign w_can_push = !r_out_valid || !i_out_stall;
    assign w_advance  = !(w_event && r_held_valid && !w_can_push);
    assign w_shift    = (r_state == S_SCAN) && w_advance;

    // output register loads on a later event in the scan or on the flush
    assign w_push = (w_shift && w_event && r_held_valid) ||
                    ((r_state == S_FLUSH) && r_held_valid && w_can_push);

    assign w_tail.acc = w_event ? w_cell[0].smp : w_cell[0].acc;
    assign w_tail.smp = w_cell[0].smp;

    for (genvar g = 0; g < PIN_COUNT; g++) begin : g_cell
        mpd_pkg::t_cell_bits w_next;
        if (g == PIN_COUNT - 1) begin : g_last
            assign w_next = w_tail;
        end else begin : g_mid
            assign w_next = w_cell[g + 1];
        end
        mpd_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load_smp (w_load_smp),
            .i_load_acc (w_load_acc),
            .i_bit      (w_sample[15 - g]),
            .i_shift    (w_shift),
            .i_next     (w_next),
            .o_bits     (w_cell[g])
        );
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_map <= mpd_pkg::PIN_MAP_RESET;
            for (int k = 0; k < 4; k++) begin
                r_deb[k] <= mpd_pkg::DEB_RESET;
            end
        end else if (i_cfg_we) begin
            priority if (i_cfg_index == mpd_pkg::REG_PIN_MAP) begin
                r_pin_map <= i_cfg_data;
            end else if (i_cfg_index <= mpd_pkg::REG_DEB_3) begin
                r_deb[2'(i_cfg_index - mpd_pkg::REG_DEB_0)] <= i_cfg_data;
            end else begin
                r_pin_map <= r_pin_map;
            end
        end
    end

    // per virtual pin pending flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_shift) begin
            if (!w_diff) begin
                r_pending[w_vpin] <= 1'b0;
            end else if (!r_pending[w_vpin]) begin
                r_pending[w_vpin] <= 1'b1;
            end else if (w_event) begin
                r_pending[w_vpin] <= 1'b0;
            end
        end
    end

    // start times, restarted on a match or on a fresh difference
    always_ff @(posedge i_clk) begin
        if (w_shift && (!w_diff || !r_pending[w_vpin])) begin
            r_start[w_vpin] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_smp) begin
            r_now <= i_now_ms[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= w_push || (r_out_valid && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (w_load_smp) begin
                        r_step  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_advance) begin
                        if (w_event) begin
                            // a held event leaves once a later one is found, or at the flush
                            if (r_held_valid) begin
                                r_out       <= r_held;
                                r_out_last  <= 1'b0;
                            end
                            r_held.vpin  <= w_vpin;
                            r_held.level <= w_cell[0].smp;
                            r_held_valid <= 1'b1;
                        end
                        if (r_step == STEP_W'(PIN_COUNT - 1)) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_held_valid) begin
                        r_state <= S_IDLE;
                    end else if (w_can_push) begin
                        r_out        <= r_held;
                        r_out_last   <= 1'b1;
                        r_held_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_virtual_pin = r_out.vpin;
    assign o_level       = r_out.level;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for the multi-pin debouncer with a scoreboard class
`timescale 1ns / 1ps

module testbench;

    localparam int PIN_COUNT     = 16;
    localparam int TIME_BITS     = 32;
    localparam int SETTLE_CYCLES = 2 * PIN_COUNT + 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_COUNT   = 7;
    localparam int PHASE_BEATS   = 62;

    localparam logic KIND_SCAN    = 1'b0;
    localparam logic KIND_PRELOAD = 1'b1;

    typedef struct packed {
        logic [mpd_pkg::VPIN_W-1:0] vpin;
        logic                       level;
        logic                       last;
    } pin_event_t;

    // predictor of debounced pin events plus the queue of events still owed
    class debounce_scoreboard;
        logic [63:0] pin_map;
        logic [63:0] deb_regs [4];
        logic [15:0] accepted;
        bit          pending [16];
        logic [31:0] start_ms [16];
        pin_event_t  owed_events [$];
        int          errors;
        int          events_checked;
        int          scans;
        int          preloads;

        function new();
            pin_map = mpd_pkg::PIN_MAP_RESET;
            foreach (deb_regs[i]) deb_regs[i] = mpd_pkg::DEB_RESET;
            accepted = '0;
            foreach (pending[i]) begin
                pending[i]  = 1'b0;
                start_ms[i] = '0;
            end
            errors         = 0;
            events_checked = 0;
            scans          = 0;
            preloads       = 0;
        endfunction

        function void write_reg(logic [mpd_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
            if (idx == mpd_pkg::REG_PIN_MAP) begin
                pin_map = data;
            end else begin
                deb_regs[idx - mpd_pkg::REG_DEB_0] = data;
            end
        endfunction

        function int outstanding();
            return owed_events.size();
        endfunction

        function void note_beat(logic kind, logic [15:0] smp, logic [31:0] now);
            pin_event_t  found [$];
            pin_event_t  ev;
            logic [3:0]  v;
            logic [15:0] hold;
            logic [31:0] elapsed;
            int          bp;
            if (kind == KIND_PRELOAD) begin
                accepted = smp;
                preloads++;
                return;
            end
            scans++;
            for (int p = 0; p < PIN_COUNT; p++) begin
                bp = 15 - p;
                v  = pin_map[4*p +: 4];
                if (smp[bp] != accepted[bp]) begin
                    if (!pending[v]) begin
                        pending[v]  = 1'b1;
                        start_ms[v] = now;
                    end else begin
                        elapsed = now - start_ms[v];
                        hold    = deb_regs[v[3:2]][16*v[1:0] +: 16];
                        if (elapsed > {16'd0, hold}) begin
                            ev.vpin  = v;
                            ev.level = smp[bp];
                            ev.last  = 1'b0;
                            found.push_back(ev);
                            accepted[bp] = smp[bp];
                            pending[v]   = 1'b0;
                        end
                    end
                end else begin
                    // back at the accepted level: any pending change is dropped
                    start_ms[v] = now;
                    pending[v]  = 1'b0;
                end
            end
            if (found.size() > 0) found[found.size()-1].last = 1'b1;
            foreach (found[i]) owed_events.push_back(found[i]);
        endfunction

        function void check_event(logic [3:0] vpin, logic level, logic last);
            pin_event_t want;
            if (owed_events.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected event: vpin %0d level %0b last %0b", vpin, level, last);
                return;
            end
            want = owed_events.pop_front();
            events_checked++;
            if (vpin !== want.vpin || level !== want.level || last !== want.last) begin
                errors++;
                if (errors <= 10)
                    $display("event mismatch: expected vpin %0d level %0b last %0b, got vpin %0d level %0b last %0b",
                             want.vpin, want.level, want.last, vpin, level, last);
            end
        endfunction

        function void flush_owed();
            if (owed_events.size() > 0) begin
                errors += owed_events.size();
                $display("%0d expected events never arrived", owed_events.size());
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_kind = 1'b0;
    logic [7:0]  i_bank_a_byte = '0;
    logic [7:0]  i_bank_b_byte = '0;
    logic [31:0] i_now_ms = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [mpd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [mpd_pkg::CFG_W-1:0]     i_cfg_data = '0;

    wire                        o_in_stall;
    wire                        o_out_valid;
    wire [mpd_pkg::VPIN_W-1:0]  o_virtual_pin;
    wire                        o_level;
    wire                        o_last;

    debounce_scoreboard sb;
    logic [31:0] now_ms_cur;
    int          stall_pct = 0;
    int          stall_left = 0;
    bit          gaps_on = 1'b1;
    int          quiet_cycles = 0;
    int          reg_settings = 1;

    multi_pin_debounce_events #(
        .PIN_COUNT (PIN_COUNT),
        .TIME_BITS (TIME_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_bank_a_byte (i_bank_a_byte),
        .i_bank_b_byte (i_bank_b_byte),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_virtual_pin (o_virtual_pin),
        .o_level       (o_level),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // output side back-pressure: short random stalls with the odd long one
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            sb.check_event(o_virtual_pin, o_level, o_last);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 12);
        if (r < 85) return $urandom_range(13, 300);
        if (r < 95) return $urandom_range(32'h1_0000, 32'h2_0000);
        return $urandom;
    endfunction

    function automatic logic [15:0] sparse_mask();
        return 16'($urandom & $urandom & $urandom);
    endfunction

    function automatic logic [63:0] shuffled_map();
        logic [3:0]  lane [16];
        logic [3:0]  tmp;
        logic [63:0] m;
        int          j;
        for (int i = 0; i < 16; i++) lane[i] = 4'(i);
        for (int i = 15; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = lane[i];
            lane[i] = lane[j];
            lane[j] = tmp;
        end
        for (int i = 0; i < 16; i++) m[4*i +: 4] = lane[i];
        return m;
    endfunction

    function automatic logic [63:0] crowded_map();
        logic [63:0] m;
        for (int i = 0; i < 16; i++) m[4*i +: 4] = 4'($urandom_range(0, 3));
        return m;
    endfunction

    function automatic logic [63:0] random_deb_reg();
        logic [63:0] r;
        int          pick;
        for (int l = 0; l < 4; l++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)       r[16*l +: 16] = 16'($urandom_range(0, 20));
            else if (pick < 8)  r[16*l +: 16] = 16'($urandom_range(0, 200));
            else if (pick == 8) r[16*l +: 16] = 16'hFFFF;
            else                r[16*l +: 16] = 16'($urandom);
        end
        return r;
    endfunction

    // hold the beat until taken, then maybe drop valid for a while
    task automatic send_beat(input logic kind, input logic [15:0] smp, input logic [31:0] now);
        int gap;
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_bank_a_byte <= smp[15:8];
        i_bank_b_byte <= smp[7:0];
        i_now_ms      <= now;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_beat(kind, smp, now);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic scan_after(input logic [15:0] smp, input logic [31:0] dt);
        now_ms_cur = now_ms_cur + dt;
        send_beat(KIND_SCAN, smp, now_ms_cur);
    endtask

    task automatic scan_at(input logic [15:0] smp, input logic [31:0] t);
        now_ms_cur = t;
        send_beat(KIND_SCAN, smp, t);
    endtask

    task automatic wait_for_events();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // a scan with no events may still be running once the queue is empty
    task automatic settle();
        wait_for_events();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [63:0] map, input logic [63:0] d0,
                                input logic [63:0] d1, input logic [63:0] d2,
                                input logic [63:0] d3);
        logic [63:0] vals [5];
        logic [mpd_pkg::CFG_IDX_W-1:0] idx;
        vals = '{map, d0, d1, d2, d3};
        idx  = mpd_pkg::REG_PIN_MAP;
        for (int i = 0; i < 5; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            sb.write_reg(idx, vals[i]);
            idx = idx + 1'b1;
        end
        i_cfg_we <= 1'b0;
        reg_settings++;
    endtask

    task automatic run_phase(input int beats);
        int          sent;
        int          r;
        int          hold_len;
        int          pause_at;
        logic [15:0] target;
        logic [15:0] prev;
        sent     = 0;
        pause_at = $urandom_range(10, beats - 10);
        while (sent < beats) begin
            if (pause_at >= 0 && sent >= pause_at) begin
                wait_for_events();
                pause_at = -1;
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                // a few pins move and the new level is held for two to six scans
                target   = sb.accepted ^ sparse_mask();
                hold_len = $urandom_range(2, 6);
                repeat (hold_len) scan_after(target, pick_step());
                sent += hold_len;
            end else if (r < 80) begin
                scan_after(16'($urandom), pick_step());
                sent++;
            end else if (r < 88) begin
                send_beat(KIND_PRELOAD, 16'($urandom), $urandom);
                sent++;
            end else begin
                // bounce: change, fall back, change again
                prev   = sb.accepted;
                target = prev ^ sparse_mask();
                scan_after(target, pick_step());
                scan_after(prev, pick_step());
                scan_after(target, pick_step());
                scan_after(target, pick_step());
                sent += 4;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: identity map, 50 ms everywhere
        scan_at(16'h0000, 32'd100);
        send_beat(KIND_PRELOAD, 16'hFFFF, 32'd0);
        scan_at(16'h0000, 32'd1000);
        scan_at(16'h0000, 32'd1050);
        scan_at(16'h0000, 32'd1051);
        scan_at(16'hFF00, 32'd2000);
        scan_at(16'hA500, 32'd2020);
        scan_at(16'hFF00, 32'd2100);
        scan_at(16'hFF00, 32'd2151);
        // change starts just before the timestamp wraps
        scan_at(16'h00FF, 32'hFFFF_FFF0);
        scan_at(16'h00FF, 32'h0000_0030);
        send_beat(KIND_PRELOAD, 16'h0000, 32'hFFFF_FFFF);

        // every pin on virtual pin 0 with a zero debounce time
        settle();
        program_regs(64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h0001_0002_0003_0004, 64'hFFFF_0000_FFFF_0000);
        scan_at(16'hFFFF, 32'd5000);
        scan_at(16'hFFFF, 32'd5001);
        scan_at(16'hFFFF, 32'd5001);

        // every pin on virtual pin 15 with the longest debounce time
        settle();
        program_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h0001_0002_0003_0004, 64'hFFFF_0000_FFFF_0000);
        send_beat(KIND_PRELOAD, 16'h0000, 32'd0);
        scan_at(16'h8000, 32'd10);
        scan_at(16'h8000, 32'd10 + 32'd65535);
        scan_at(16'h8000, 32'd10 + 32'd65536);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle();
            case (ph)
                0: begin
                    program_regs(shuffled_map(), 64'h0, 64'h0, 64'h0, 64'h0);
                end
                1: begin
                    program_regs(64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFFF,
                                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                 64'hFFFF_FFFF_FFFF_FFFF);
                end
                2: begin
                    program_regs(64'h0, random_deb_reg(), random_deb_reg(),
                                 random_deb_reg(), random_deb_reg());
                end
                3: begin
                    program_regs(64'hFFFF_FFFF_FFFF_FFFF, random_deb_reg(), random_deb_reg(),
                                 random_deb_reg(), random_deb_reg());
                end
                4: begin
                    program_regs({$urandom, $urandom}, random_deb_reg(), random_deb_reg(),
                                 random_deb_reg(), random_deb_reg());
                end
                5: begin
                    program_regs(crowded_map(), random_deb_reg(), random_deb_reg(),
                                 random_deb_reg(), random_deb_reg());
                end
                default: begin
                    program_regs(mpd_pkg::PIN_MAP_RESET, mpd_pkg::DEB_RESET,
                                 mpd_pkg::DEB_RESET, mpd_pkg::DEB_RESET, mpd_pkg::DEB_RESET);
                end
            endcase
            case (ph % 3)
                0: stall_pct = 0;
                1: stall_pct = 15;
                default: stall_pct = 45;
            endcase
            gaps_on    = (ph != 2 && ph != 5);
            now_ms_cur = (ph == 3) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
            run_phase(PHASE_BEATS);
        end

        settle();
        sb.flush_owed();
        $display("covered %0d scans and %0d preloads across %0d register settings",
                 sb.scans, sb.preloads, reg_settings);
        $display("%0d events checked, %0d mismatches", sb.events_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/mpd_pkg.sv
src/mpd_cell.sv
src/multi_pin_debounce_events.sv
tb/testbench.sv
